// ===== design/assert_macros.svh =====
// Assertion macros used by the zone tracker top level.
// Depends on a clock and reset named clock and reset in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset
`define SVZT_ASSERT(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define SVZT_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== design/svzt_pkg.sv =====
// Shared types and constants for the speeding vehicle zone tracker.
// Used by the controller, datapath and top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package svzt_pkg;

   localparam int MAX_VEHICLES = 64;
   localparam int IDX_W        = $clog2(MAX_VEHICLES);

   localparam int ID_W    = 32;
   localparam int ZONE_W  = 4;
   localparam int SPEED_W = 12;
   localparam int TIME_W  = 48;
   localparam int MSG_W   = 2;

   localparam int REQ_W  = 96;
   localparam int RSP_W  = 8;
   localparam int CSR_AW = 2;
   localparam int CSR_DW = 32;

   localparam logic [CSR_AW-1:0] REG_SPEED_LIMIT = 2'd0;
   localparam logic [CSR_AW-1:0] REG_SNAP        = 2'd1;
   localparam logic [CSR_AW-1:0] REG_TIMEOUT     = 2'd2;

   localparam logic [7:0]  SPEED_LIMIT_RESET = 8'd25;
   localparam logic [31:0] SNAP_RESET        = 32'd1000;
   localparam logic [31:0] TIMEOUT_RESET     = 32'd5000;

   localparam logic [MSG_W-1:0]  WARN_MESSAGE   = 2'd3;
   localparam logic [MSG_W-1:0]  BLANK_MESSAGE  = 2'd0;
   localparam logic [ZONE_W-1:0] WARN_ZONE_LOW  = 4'd1;
   localparam logic [ZONE_W-1:0] WARN_ZONE_HIGH = 4'd3;

   typedef struct packed {
      logic [TIME_W-1:0]  stamp;
      logic [SPEED_W-1:0] speed;
      logic [ZONE_W-1:0]  zone;
      logic [ID_W-1:0]    id;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_COMMIT,
      ST_SWEEP,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic lookup;
      logic commit;
      logic sweep;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic out_busy;
   } sts_type;

endpackage
`default_nettype wire

// ===== design/svzt_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module svzt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule
`default_nettype wire

// ===== design/svzt_ctrl.sv =====
// Sequencing controller for the zone tracker: lookup, commit, sweep, emit.
// Depends on svzt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module svzt_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire svzt_pkg::sts_type sts,
   output svzt_pkg::cmd_type      cmd
);
   import svzt_pkg::*;

   state_type state_ff, state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_tvalid) state_in = ST_LOOKUP;
         ST_LOOKUP: if (sts.scan_done) state_in = ST_COMMIT;
         ST_COMMIT: state_in = ST_SWEEP;
         ST_SWEEP:  if (sts.scan_done) state_in = ST_DONE;
         ST_DONE:   if (!sts.out_busy) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_LOOKUP: cmd.lookup = 1'b1;
         ST_COMMIT: cmd.commit = 1'b1;
         ST_SWEEP:  cmd.sweep  = 1'b1;
         ST_DONE:   cmd.emit   = !sts.out_busy;
         default:   cmd        = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ===== design/svzt_datapath.sv =====
// Datapath for the zone tracker: vehicle table, scan logic, config and result register.
// Depends on svzt_pkg and svzt_ram.
`timescale 1ns / 1ps
`default_nettype none
module svzt_datapath (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic [svzt_pkg::REQ_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   output logic      [svzt_pkg::RSP_W-1:0]   rsp_tdata,
   input  wire logic                         csr_we,
   input  wire logic [svzt_pkg::CSR_AW-1:0]  csr_addr,
   input  wire logic [svzt_pkg::CSR_DW-1:0]  csr_wdata,
   input  wire svzt_pkg::cmd_type            cmd,
   output svzt_pkg::sts_type                 sts
);
   import svzt_pkg::*;

   localparam logic [IDX_W:0] SCAN_END = (IDX_W+1)'(MAX_VEHICLES);

   // Configuration registers
   logic [7:0]  limit_ff;
   logic [31:0] snap_ff;
   logic [31:0] timeout_ff;

   // Captured transaction
   entry_type req_ff;

   // Scan counter and read pipeline
   logic [IDX_W:0]   cnt_ff, cnt_in;
   logic             pend_ff, pend_in;
   logic [IDX_W-1:0] pidx_ff;

   // Lookup results
   logic              found_ff, found_in;
   logic [IDX_W-1:0]  hit_ff, hit_in;
   logic [TIME_W-1:0] hit_time_ff, hit_time_in;
   logic              any_ff, any_in;
   logic [IDX_W-1:0]  free_ff, free_in;
   logic              full_ff, full_in;
   logic [ZONE_W-1:0] top_ff, top_in;

   logic [MAX_VEHICLES-1:0] valid_ff, valid_in;
   logic [MSG_W-1:0]        last_ff;
   logic                    out_valid_ff;
   logic [RSP_W-1:0]        out_data_ff;

   // Table memory
   logic                ram_we;
   logic [IDX_W-1:0]    ram_waddr;
   logic [ENTRY_W-1:0]  ram_rdata;
   entry_type           rd;
   logic                vld_rd;
   logic [TIME_W-1:0]   age_rd;
   logic [TIME_W-1:0]   hit_age;
   logic                expire_rd;
   logic                scan_on;
   logic [MSG_W-1:0]    msg;

   svzt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_VEHICLES)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (req_ff),
      .raddr (cnt_ff[IDX_W-1:0]),
      .rdata (ram_rdata)
   );

   assign rd        = entry_type'(ram_rdata);
   assign vld_rd    = valid_ff[pidx_ff];
   assign age_rd    = req_ff.stamp - rd.stamp;
   assign hit_age   = req_ff.stamp - hit_time_ff;
   assign expire_rd = age_rd > {16'd0, timeout_ff};
   assign scan_on   = cmd.lookup | cmd.sweep;

   // Advance the scan address; read data lands in the following cycle
   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.load || cmd.commit) begin
         cnt_in = '0;
      end else if (scan_on && cnt_ff != SCAN_END) begin
         cnt_in = cnt_ff + 1'b1;
      end
      pend_in = scan_on && (cnt_ff != SCAN_END);
   end

   assign sts.scan_done = (cnt_ff == SCAN_END) && !pend_ff;
   assign sts.out_busy  = out_valid_ff && !rsp_tready;

   // Lookup, commit and sweep
   always_comb begin
      found_in    = found_ff;
      hit_in      = hit_ff;
      hit_time_in = hit_time_ff;
      any_in      = any_ff;
      free_in     = free_ff;
      full_in     = full_ff;
      top_in      = top_ff;
      valid_in    = valid_ff;
      ram_we      = 1'b0;
      ram_waddr   = hit_ff;

      if (cmd.load) begin
         found_in = 1'b0;
         any_in   = 1'b0;
         full_in  = 1'b0;
         top_in   = '0;
      end

      // Find matching id and lowest free slot
      if (cmd.lookup && pend_ff) begin
         if (vld_rd) begin
            if (!found_ff && rd.id == req_ff.id) begin
               found_in    = 1'b1;
               hit_in      = pidx_ff;
               hit_time_in = rd.stamp;
            end
         end else if (!any_ff) begin
            any_in  = 1'b1;
            free_in = pidx_ff;
         end
      end

      // Insert, update or remove
      if (cmd.commit) begin
         if (found_ff) begin
            if (req_ff.zone == '0 && hit_age < {16'd0, snap_ff}) begin
               valid_in[hit_ff] = 1'b0;
            end else begin
               ram_we = 1'b1;
            end
         end else if (req_ff.zone != '0) begin
            if (any_ff) begin
               ram_we            = 1'b1;
               ram_waddr         = free_ff;
               valid_in[free_ff] = 1'b1;
            end else begin
               full_in = 1'b1;
            end
         end
      end

      // Expire stale entries and track the lowest speeding zone
      if (cmd.sweep && pend_ff && vld_rd) begin
         if (expire_rd) begin
            valid_in[pidx_ff] = 1'b0;
         end else if (rd.zone != '0 && rd.speed > {limit_ff, 4'd0} &&
                      (top_ff == '0 || rd.zone < top_ff)) begin
            top_in = rd.zone;
         end
      end
   end

   assign msg = (top_ff >= WARN_ZONE_LOW && top_ff <= WARN_ZONE_HIGH) ?
                WARN_MESSAGE : BLANK_MESSAGE;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= SPEED_LIMIT_RESET;
         snap_ff      <= SNAP_RESET;
         timeout_ff   <= TIMEOUT_RESET;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         valid_ff     <= '0;
         last_ff      <= BLANK_MESSAGE;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_addr)
               REG_SPEED_LIMIT: limit_ff   <= csr_wdata[7:0];
               REG_SNAP:        snap_ff    <= csr_wdata;
               REG_TIMEOUT:     timeout_ff <= csr_wdata;
               default:         ;
            endcase
         end
         cnt_ff   <= cnt_in;
         pend_ff  <= pend_in;
         valid_ff <= valid_in;
         if (cmd.emit) begin
            last_ff      <= msg;
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= entry_type'(req_tdata);
      end
      pidx_ff     <= cnt_ff[IDX_W-1:0];
      found_ff    <= found_in;
      hit_ff      <= hit_in;
      hit_time_ff <= hit_time_in;
      any_ff      <= any_in;
      free_ff     <= free_in;
      full_ff     <= full_in;
      top_ff      <= top_in;
      if (cmd.emit) begin
         out_data_ff <= {full_ff, top_ff, msg != last_ff, msg};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule
`default_nettype wire

// ===== design/speeding_vehicle_zone_tracker.sv =====
// Top level of the speeding vehicle zone tracker.
// Depends on svzt_pkg, svzt_ctrl, svzt_datapath (with svzt_ram) and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
// Each report goes from acceptance to a result in the output register in steps: one
// pass over the table memory's single read port to look up the id and the lowest free
// slot, a commit step to write the entry, and a second pass to expire stale entries
// and find the lowest speeding zone. A finished result waits in the output register
// while the next report is already taken. The valid bits clear at reset, so no
// clearing pass is needed.
`include "assert_macros.svh"
module speeding_vehicle_zone_tracker (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   // vehicle_id[31:0], zone[35:32], speed[47:36], now_ms[95:48]
   input  wire logic [svzt_pkg::REQ_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   // sign_message[1:0], send_message[2], top_zone[6:3], table_full[7]
   output logic      [svzt_pkg::RSP_W-1:0]   rsp_tdata,
   input  wire logic                         csr_we,
   input  wire logic [svzt_pkg::CSR_AW-1:0]  csr_addr,
   input  wire logic [svzt_pkg::CSR_DW-1:0]  csr_wdata
);
   import svzt_pkg::*;

   cmd_type cmd;
   sts_type sts;

   svzt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   svzt_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .sts        (sts)
   );

   // Check command exclusivity, result handoff and message mapping
   `SVZT_ASSERT(a_cmd_onehot, $onehot0({cmd.load, cmd.lookup, cmd.commit, cmd.sweep, cmd.emit}), "commands overlap")
   `SVZT_ASSERT_IMPL(a_emit_free, cmd.emit, !(rsp_tvalid && !rsp_tready), "result overwritten")
   `SVZT_ASSERT_IMPL(a_msg_map, rsp_tvalid, (rsp_tdata[1:0] == WARN_MESSAGE) == (rsp_tdata[6:3] >= WARN_ZONE_LOW && rsp_tdata[6:3] <= WARN_ZONE_HIGH), "sign message mismatch")

endmodule
`default_nettype wire
